### rtl/atpf_pkg.sv
// ----------------------------------------------------------------------------
// atpf_pkg
// Shared types and constants of the ASCII telemetry packet framer.
// ----------------------------------------------------------------------------
package atpf_pkg;

    localparam int SEQ_W = 16;

    localparam logic [SEQ_W-1:0] SEQ_LIMIT = 16'd60000;

    localparam logic [7:0] CH_START = 8'h2A;   // '*'
    localparam logic [7:0] CH_SEP   = 8'h2C;   // ','
    localparam logic [7:0] CH_END   = 8'h23;   // '#'
    localparam logic [7:0] CH_MINUS = 8'h2D;   // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'

    // number fields of a frame: sequence number, then three values
    localparam logic [1:0] FIELD_SEQ  = 2'd0;
    localparam logic [1:0] FIELD_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREFIX,
        ST_SIGN,
        ST_DIGIT,
        ST_END
    } frm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

endpackage

### rtl/atpf_if.sv
// ----------------------------------------------------------------------------
// atpf_if
// Valid/ready channels of the framer: measurement words in, frame bytes out.
// ----------------------------------------------------------------------------
interface atpf_sample_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] rpm_delta;
    logic signed [VALUE_WIDTH-1:0] speed_delta;
    logic signed [VALUE_WIDTH-1:0] exhaust_temp;

    modport source (
        output valid, rpm_delta, speed_delta, exhaust_temp,
        input  ready
    );
    modport sink (
        input  valid, rpm_delta, speed_delta, exhaust_temp,
        output ready
    );
endinterface

interface atpf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (
        output valid, frame_byte, frame_end,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_end,
        output ready
    );
endinterface

### rtl/atpf_bcd_conv.sv
// ----------------------------------------------------------------------------
// atpf_bcd_conv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module atpf_bcd_conv #(
    parameter int MAG_W = 16,
    parameter int ND    = 5,
    parameter int IDX_W = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [MAG_W-1:0]      mag,
    output atpf_pkg::conv_status_t status,
    output logic [ND-1:0][3:0]    digits,
    output logic [IDX_W-1:0]      lead_idx
);
    import atpf_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [ND-1:0][3:0] bcd_reg, bcd_next, bcd_adj;
    logic [ND*4:0]      bcd_shift;
    logic [MAG_W-1:0]   bin_reg, bin_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // digit shift: top bit of the adjusted vector is always zero
    assign bcd_shift = {bcd_adj[ND-1:0], bin_reg[MAG_W-1]};

    always_comb
    begin
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            bcd_next   = '0;
            bin_next   = mag;
            count_next = CNT_W'(MAG_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next   = bcd_shift[ND*4-1:0];
            bin_next   = {bin_reg[MAG_W-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // most significant nonzero digit; zero prints as one digit
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    assign digits      = bcd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/ascii_telemetry_packet_framer.sv
// ----------------------------------------------------------------------------
// ascii_telemetry_packet_framer
// Turns three signed measurement values into one ASCII telemetry frame.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready sink, one word carries rpm_delta, speed_delta and
//            exhaust_temp (signed, VALUE_WIDTH bits each).
//   frame  : valid/ready source, one word per frame byte; frame_end marks
//            the closing '#'. A frame reads *seq,v1,v2,v3# in plain decimal.
// Each accepted word bumps the sequence counter (cleared first if above
// 60000), so frames are numbered 1..60001.
// Flow: the four numbers go one after the other through a single
// shift-and-add-3 converter, one bit per cycle, MAG_W = max(VALUE_WIDTH,16)
// bits per number; after each conversion the bytes of that number go out
// whenever the output is free. The first byte follows the conversion of
// the sequence number.
// sample.ready is high only while no frame is in progress.
// Stall: a held output byte freezes the sequencer; nothing is dropped.
// Reset clears the counter, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module ascii_telemetry_packet_framer #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    atpf_sample_if.sink  sample,
    atpf_frame_if.source frame
);
    import atpf_pkg::*;

    localparam int MAG_W      = (VALUE_WIDTH > SEQ_W) ? VALUE_WIDTH : SEQ_W;
    // decimal digits needed for MAG_W bits: floor(MAG_W*log10(2)) + 1
    localparam int NUM_DIGITS = (MAG_W * 1233) / 4096 + 1;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    frm_state_t                   state_reg, state_next;
    logic [SEQ_W-1:0]             seq_reg, seq_next;
    logic [2:0][VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [1:0]                   field_reg, field_next;
    logic                         neg_reg, neg_next;
    logic [IDX_W-1:0]             digit_idx_reg, digit_idx_next;
    logic                         out_valid_reg;
    logic [7:0]                   out_byte_reg;
    logic                         out_end_reg;

    logic                         emit;
    logic [7:0]                   emit_byte;
    logic                         emit_end;
    logic                         slot_free;

    logic                         conv_start;
    logic [MAG_W-1:0]             conv_mag;
    conv_status_t                 conv_stat;
    logic [NUM_DIGITS-1:0][3:0]   conv_digits;
    logic [IDX_W-1:0]             conv_lead;
    logic [3:0]                   cur_digit;
    logic [VALUE_WIDTH-1:0]       next_abs;

    atpf_bcd_conv #(
        .MAG_W (MAG_W),
        .ND    (NUM_DIGITS),
        .IDX_W (IDX_W)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (conv_start),
        .mag      (conv_mag),
        .status   (conv_stat),
        .digits   (conv_digits),
        .lead_idx (conv_lead)
    );

    assign slot_free = !out_valid_reg || frame.ready;
    assign cur_digit = conv_digits[digit_idx_reg];
    // magnitude of the next value; the most negative one maps to 2^(W-1)
    assign next_abs  = val_reg[0][VALUE_WIDTH-1] ? (~val_reg[0] + 1'b1) : val_reg[0];

    assign sample.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        val_next       = val_reg;
        field_next     = field_reg;
        neg_next       = neg_reg;
        digit_idx_next = digit_idx_reg;
        conv_start     = 1'b0;
        conv_mag       = '0;
        emit           = 1'b0;
        emit_byte      = CH_START;
        emit_end       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    seq_next    = ((seq_reg > SEQ_LIMIT) ? '0 : seq_reg) + 1'b1;
                    val_next[0] = sample.rpm_delta;
                    val_next[1] = sample.speed_delta;
                    val_next[2] = sample.exhaust_temp;
                    field_next  = FIELD_SEQ;
                    neg_next    = 1'b0;
                    conv_start  = 1'b1;
                    conv_mag    = MAG_W'(seq_next);
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_stat.done)
                begin
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_byte      = (field_reg == FIELD_SEQ) ? CH_START : CH_SEP;
                    digit_idx_next = conv_lead;
                    state_next     = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = CH_MINUS;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = CH_ZERO + {4'h0, cur_digit};
                    if (digit_idx_reg != '0)
                    begin
                        digit_idx_next = digit_idx_reg - 1'b1;
                    end
                    else if (field_reg == FIELD_LAST)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        // next value leaves the head of the value queue
                        field_next  = field_reg + 1'b1;
                        neg_next    = val_reg[0][VALUE_WIDTH-1];
                        conv_start  = 1'b1;
                        conv_mag    = MAG_W'(next_abs);
                        val_next[0] = val_reg[1];
                        val_next[1] = val_reg[2];
                        state_next  = ST_CONV;
                    end
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = CH_END;
                    emit_end   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        field_reg     <= field_next;
        neg_reg       <= neg_next;
        digit_idx_reg <= digit_idx_next;
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_end_reg  <= emit_end;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_end  = out_end_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_end_is_hash: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_byte_reg == CH_END)
        else $error("frame end flag on a byte other than the closing mark");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg <= SEQ_LIMIT + 1'b1)
        else $error("sequence counter out of range");

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.done |-> state_reg == ST_CONV)
        else $error("conversion finished outside the conversion state");

    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && !conv_stat.done |-> conv_stat.busy)
        else $error("sequencer waits on an idle converter");

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGIT |-> cur_digit <= 4'd9)
        else $error("converter produced a digit above nine");

endmodule
